/* rtl/core/lnc_pkg.sv */
// lnc_pkg: shared types and fixed sizes for the logistic neuron classifier
// holds the queue entry, queue status and register set structs
// no dependencies
package lnc_pkg;

  localparam int LNC_ACC_W  = 40;
  localparam int LNC_QDEPTH = 4;
  localparam int LNC_QAW    = 2;
  localparam int LNC_QCW    = 3;

  // one pixel operation handed from the front end to the datapath
  typedef struct packed {
    logic [7:0]  pixel;
    logic [15:0] weight;
    logic        last;
    logic        acc_en;
  } lnc_op_t;

  typedef struct packed {
    logic               nonempty;
    logic [LNC_QCW-1:0] count;
  } lnc_qstat_t;

  typedef struct packed {
    logic [15:0] bias;
    logic [15:0] threshold;
  } lnc_cfg_t;

endpackage

/* rtl/core/lnc_fifo.sv */
// lnc_fifo: short operation queue between the front end and the datapath
// depends on lnc_pkg for the entry type and depth
module lnc_fifo
  import lnc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lnc_op_t    push_op_i,
  input  logic       pop_i,
  output lnc_op_t    pop_op_o,
  output lnc_qstat_t qstat_o
);

  lnc_op_t            slot_q [LNC_QDEPTH];
  logic [LNC_QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [LNC_QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LNC_QCW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + LNC_QAW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + LNC_QAW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + LNC_QCW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - LNC_QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign pop_op_o         = slot_q[rd_ptr_q];
  assign qstat_o.nonempty = (count_q != '0);
  assign qstat_o.count    = count_q;

endmodule

/* rtl/core/lnc_front.sv */
// lnc_front: input beat acceptance, weight memory and element counter
// classifies beats into weight writes and pixel operations for the queue
// depends on lnc_pkg
module lnc_front
  import lnc_pkg::*;
#(
  parameter int MAX_FEATURES = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [13:0]        weight_index_i,
  input  logic signed [15:0] weight_value_i,
  input  logic [7:0]         pixel_i,
  input  logic               last_element_i,
  input  lnc_qstat_t         qstat_i,
  output logic               push_o,
  output lnc_op_t            push_op_o
);

  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  localparam int AW = $clog2(MAX_FEATURES);
  localparam int CW = $clog2(MAX_FEATURES + 1);
  localparam int XW = (CW > 14) ? CW : 14;

  logic [15:0]   wmem [MAX_FEATURES];
  logic [15:0]   rdata_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          f1_valid_q;
  logic [7:0]    f1_pixel_q;
  logic          f1_last_q;
  logic          f1_en_q;

  logic [LNC_QCW:0] used;
  logic             accept;
  logic             pix_acc;
  logic             wr_en;
  logic             cnt_en;
  logic [XW-1:0]    idx_x;

  // in-flight beat counts against the queue so a push always finds room
  assign used       = {1'b0, qstat_i.count} + {{LNC_QCW{1'b0}}, f1_valid_q};
  assign in_stall_o = (used >= (LNC_QCW + 1)'(LNC_QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign idx_x   = XW'(weight_index_i);
  assign wr_en   = accept && (mode_i == MODE_WEIGHT) && (idx_x < XW'(MAX_FEATURES));
  assign pix_acc = accept && (mode_i == MODE_PIXEL);
  assign cnt_en  = (cnt_q < CW'(MAX_FEATURES));

  always_comb begin
    cnt_d = cnt_q;
    if (pix_acc) begin
      if (last_element_i) begin
        cnt_d = '0;
      end else if (cnt_en) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      f1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      f1_pixel_q <= pixel_i;
      f1_last_q  <= last_element_i;
      f1_en_q    <= cnt_en;
    end
  end

  // write and read in beat order, so a weight is visible to the next beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[idx_x[AW-1:0]] <= weight_value_i;
    end
    if (pix_acc && cnt_en) begin
      rdata_q <= wmem[cnt_q[AW-1:0]];
    end
  end

  assign push_o           = f1_valid_q;
  assign push_op_o.pixel  = f1_pixel_q;
  assign push_op_o.weight = rdata_q;
  assign push_op_o.last   = f1_last_q;
  assign push_op_o.acc_en = f1_en_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_FEATURES))
    else $error("element counter ran past the memory depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc && last_element_i |=> cnt_q == '0)
    else $error("element counter not cleared after last pixel");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_valid_q |-> qstat_i.count < LNC_QCW'(LNC_QDEPTH))
    else $error("push into a full queue");
`endif

endmodule

/* rtl/core/lnc_back.sv */
// lnc_back: multiply-accumulate, divide by 255, bias, saturation and sigmoid lookup
// pops pixel operations from the queue and drives the result register
// depends on lnc_pkg
module lnc_back
  import lnc_pkg::*;
#(
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lnc_qstat_t         qstat_i,
  input  lnc_op_t            op_i,
  output logic               pop_o,
  input  lnc_cfg_t           cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] logit_o,
  output logic [15:0]        probability_o,
  output logic               class_label_o
);

  localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int PW = 16 + $clog2(SIGMOID_TABLE_DEPTH + 1);
  // quotients from this bound up always saturate the logit
  localparam logic [LNC_ACC_W:0] DIV_SAT = (LNC_ACC_W + 1)'(255 * 65536);
  // ceil(2^32 / 255), exact floor division for dividends below 2^24
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // one entry of the sigmoid table at its bin centre, all in Q.32
  function automatic logic [15:0] sig_entry(int depth, int idx);
    logic [63:0] one, y, term, pos, neg, c, p, den, s, v;
    int          k, j, d, u;
    one  = 64'd1 << 32;
    y    = div_u64(64'd1 << 35, 64'(depth));
    term = one;
    pos  = one;
    neg  = '0;
    for (k = 1; k < 40; k++) begin
      term = div_u64(term * y, 64'(k) << 32);
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    c = pos - neg;
    d = 2 * idx + 1 - depth;
    u = (d < 0) ? -d : d;
    p = one;
    for (j = 0; j < u; j++) begin
      p = (p * c) >> 32;
    end
    den = one + p;
    s   = div_u64((64'd1 << 48) + (den >> 1), den);
    v   = (d >= 0) ? s : (64'd65536 - s);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  logic [15:0] sig_rom [SIGMOID_TABLE_DEPTH];

  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [15:0] ENTRY = sig_entry(SIGMOID_TABLE_DEPTH, g);
    assign sig_rom[g] = ENTRY;
  end

  logic advance;

  logic                 b1_v_q;
  logic                 b1_last_q;
  logic signed [23:0]   b1_prod_q;
  logic [LNC_ACC_W-1:0] acc_q;
  logic                 r0_v_q;
  logic [LNC_ACC_W-1:0] r0_acc_q;
  logic                 r1_v_q, r1_neg_q, r1_sat_q;
  logic [23:0]          r1_m_q;
  logic                 r2_v_q, r2_neg_q;
  logic [16:0]          r2_q_q;
  logic                 r3_v_q;
  logic [15:0]          r3_logit_q;
  logic                 r4_v_q;
  logic [15:0]          r4_logit_q;
  logic [IW-1:0]        r4_idx_q;
  logic                 out_valid_q;
  logic [15:0]          out_logit_q;
  logic [15:0]          out_prob_q;
  logic                 out_class_q;

  logic signed [24:0]   mul;
  logic signed [23:0]   prod;
  logic [LNC_ACC_W-1:0] sum;
  logic [LNC_ACC_W-1:0] mag;
  logic [LNC_ACC_W:0]   m;
  logic [48:0]          recip_prod;
  logic [16:0]          q_c;
  logic [17:0]          q18, sq;
  logic [18:0]          lsum;
  logic [15:0]          logit_c;
  logic [15:0]          off;
  logic [PW-1:0]        idx_prod;
  logic [15:0]          prob_c;

  // the whole datapath moves together unless a finished result is held
  assign advance = !(out_valid_q && out_stall_i);
  assign pop_o   = advance && qstat_i.nonempty;

  assign mul  = $signed({1'b0, op_i.pixel}) * $signed(op_i.weight);
  assign prod = op_i.acc_en ? mul[23:0] : '0;
  assign sum  = acc_q + {{(LNC_ACC_W - 24){b1_prod_q[23]}}, b1_prod_q};

  // rounded magnitude division by 255
  assign mag        = r0_acc_q[LNC_ACC_W-1] ? (~r0_acc_q + LNC_ACC_W'(1)) : r0_acc_q;
  assign m          = {1'b0, mag} + (LNC_ACC_W + 1)'(127);
  assign recip_prod = {25'b0, r1_m_q} * {24'b0, RECIP_255};
  assign q_c        = r1_sat_q ? 17'h10000 : {1'b0, recip_prod[47:32]};

  assign q18  = {1'b0, r2_q_q};
  assign sq   = r2_neg_q ? (~q18 + 18'd1) : q18;
  assign lsum = {sq[17], sq} + {{3{cfg_i.bias[15]}}, cfg_i.bias};

  always_comb begin
    if (!lsum[18] && (lsum[17:15] != 3'b000)) begin
      logit_c = 16'h7FFF;
    end else if (lsum[18] && (lsum[17:15] != 3'b111)) begin
      logit_c = 16'h8000;
    end else begin
      logit_c = lsum[15:0];
    end
  end

  // table index from the logit offset to unsigned
  assign off      = {~r3_logit_q[15], r3_logit_q[14:0]};
  assign idx_prod = PW'(off) * PW'(SIGMOID_TABLE_DEPTH);
  assign prob_c   = sig_rom[r4_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q      <= 1'b0;
      acc_q       <= '0;
      r0_v_q      <= 1'b0;
      r1_v_q      <= 1'b0;
      r2_v_q      <= 1'b0;
      r3_v_q      <= 1'b0;
      r4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      b1_v_q      <= qstat_i.nonempty;
      if (b1_v_q) begin
        acc_q <= b1_last_q ? '0 : sum;
      end
      r0_v_q      <= b1_v_q && b1_last_q;
      r1_v_q      <= r0_v_q;
      r2_v_q      <= r1_v_q;
      r3_v_q      <= r2_v_q;
      r4_v_q      <= r3_v_q;
      out_valid_q <= r4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b1_last_q   <= op_i.last;
      b1_prod_q   <= prod;
      r0_acc_q    <= sum;
      r1_neg_q    <= r0_acc_q[LNC_ACC_W-1];
      r1_sat_q    <= (m >= DIV_SAT);
      r1_m_q      <= m[23:0];
      r2_neg_q    <= r1_neg_q;
      r2_q_q      <= q_c;
      r3_logit_q  <= logit_c;
      r4_logit_q  <= r3_logit_q;
      r4_idx_q    <= idx_prod[16+IW-1:16];
      out_logit_q <= r4_logit_q;
      out_prob_q  <= prob_c;
      out_class_q <= (prob_c > cfg_i.threshold);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign logit_o       = out_logit_q;
  assign probability_o = out_prob_q;
  assign class_label_o = out_class_q;

`ifndef NO_ASSERTIONS
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && b1_v_q && b1_last_q |=> acc_q == '0)
    else $error("accumulator not cleared after a sample");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable({r0_v_q, r1_v_q, r2_v_q, r3_v_q, r4_v_q}))
    else $error("result pipeline moved while the output was held");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && r4_v_q |=> out_valid_q)
    else $error("result lost before the output register");
`endif

endmodule

/* rtl/core/logistic_neuron_classifier_unit.sv */
// logistic_neuron_classifier_unit: top level of the logistic neuron classifier
// holds the register file and joins front end, operation queue and datapath
// depends on lnc_pkg, lnc_front, lnc_fifo and lnc_back
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one beat per item.
// A beat with mode_i = 0 writes weight_value_i at weight_index_i; a beat with
// mode_i = 1 feeds one pixel, multiplied by the weight at the running element
// index. The pixel beat with last_element_i set closes the sample and yields
// one result beat (logit_o, probability_o, class_label_o) on the output channel.
// Throughput is one beat per cycle while in_stall_o is low, limited by the weight memory's
// write and read ports and the one multiply-accumulate per cycle in the datapath.
// The last pixel passes the front-end register, the queue, stage b1, stages r0 to r4 and
// the output register before the result is valid; a held output stalls this path.
// Reset clears the accumulator, the element counter and the registers (bias 0,
// threshold 0x8000); weights are undefined until written, no clearing pass.
// While out_stall_i holds a result, the datapath freezes and the four-entry
// queue keeps taking beats until it fills, then in_stall_o rises.
// Registers (APB, write only while idle): bias at 0x0, decision_threshold at 0x4.
module logistic_neuron_classifier_unit
  import lnc_pkg::*;
#(
  parameter int MAX_FEATURES        = 16384,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [13:0]        weight_index_i,
  input  logic signed [15:0] weight_value_i,
  input  logic [7:0]         pixel_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] logit_o,
  output logic [15:0]        probability_o,
  output logic               class_label_o
);

  localparam logic        REG_BIAS      = 1'b0;
  localparam logic        REG_THRESHOLD = 1'b1;
  localparam logic [15:0] THRESHOLD_RST = 16'h8000;

  logic [15:0] bias_q;
  logic [15:0] thr_q;
  logic        cfg_wr;
  lnc_cfg_t    cfg;

  lnc_qstat_t qstat;
  lnc_op_t    push_op;
  lnc_op_t    pop_op;
  logic       push;
  logic       pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      thr_q  <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BIAS:      bias_q <= pwdata[15:0];
        REG_THRESHOLD: thr_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BIAS:      prdata = {16'b0, bias_q};
      REG_THRESHOLD: prdata = {16'b0, thr_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg.bias      = bias_q;
  assign cfg.threshold = thr_q;

  lnc_front #(
    .MAX_FEATURES(MAX_FEATURES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .weight_index_i,
    .weight_value_i,
    .pixel_i,
    .last_element_i,
    .qstat_i   (qstat),
    .push_o    (push),
    .push_op_o (push_op)
  );

  lnc_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .qstat_o   (qstat)
  );

  lnc_back #(
    .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .qstat_i (qstat),
    .op_i    (pop_op),
    .pop_o   (pop),
    .cfg_i   (cfg),
    .out_valid_o,
    .out_stall_i,
    .logit_o,
    .probability_o,
    .class_label_o
  );

endmodule
